// ----- hdl/assert_macros.svh -----
// assertion macros used by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ldsc_pkg.sv -----
// shared types and constants of the serial command decoder
`timescale 1ns / 1ps

package ldsc_pkg;

  localparam int CMD_MAX     = 31;
  localparam int CMD_LEN_W   = 5;
  localparam int CMD_KEEP    = 7;
  localparam int CMD_IDX_W   = 3;

  localparam int REPLY_DEPTH = 32;
  localparam int REPLY_AW    = 5;
  localparam int REPLY_CW    = 6;
  localparam logic [REPLY_CW-1:0] REPLY_FULL = REPLY_CW'(REPLY_DEPTH);

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 2;
  localparam int OUT_DATA_W  = 56;
  localparam int DIGITS_W    = 40;
  localparam int FRAME_W     = 16;

  // frame to decimal: q = (v * RECIP_TEN) >> RECIP_SHIFT equals v / 10 for 16 bits
  localparam logic [FRAME_W-1:0] RECIP_TEN = 16'hcccd;
  localparam int RECIP_SHIFT = 19;
  localparam int QUOT_W      = 13;
  localparam logic [2:0] CONV_LAST = 3'd4;

  localparam int PUSH_IDX_W  = 3;
  localparam logic [PUSH_IDX_W-1:0] PUSH_LAST_STATUS = 3'd1;
  localparam logic [PUSH_IDX_W-1:0] PUSH_LAST_SEARCH = 3'd2;
  localparam logic [PUSH_IDX_W-1:0] PUSH_LAST_FRAME  = 3'd6;

  localparam logic [7:0] CHR_CR    = 8'h0d;
  localparam logic [7:0] CHR_STAR  = 8'h2a;
  localparam logic [7:0] CHR_COMMA = 8'h2c;
  localparam logic [7:0] CHR_SLASH = 8'h2f;
  localparam logic [7:0] CHR_ZERO  = 8'h30;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_QUEST = 8'h3f;
  localparam logic [7:0] CHR_A     = 8'h41;
  localparam logic [7:0] CHR_B     = 8'h42;
  localparam logic [7:0] CHR_F     = 8'h46;
  localparam logic [7:0] CHR_N     = 8'h4e;
  localparam logic [7:0] CHR_R     = 8'h52;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_U     = 8'h55;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_POLL  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ACT_NONE         = 4'd0,
    ACT_PAUSE        = 4'd1,
    ACT_PLAY_RESTORE = 4'd2,
    ACT_PLAY_MUTED   = 4'd3,
    ACT_SEARCH_HOLD  = 4'd4,
    ACT_SEARCH_PLAY  = 4'd5,
    ACT_AUDIO1_OFF   = 4'd6,
    ACT_AUDIO1_ON    = 4'd7,
    ACT_AUDIO2_OFF   = 4'd8,
    ACT_AUDIO2_ON    = 4'd9
  } act_t;

  typedef enum logic [2:0] {
    OP_REPORT,
    OP_READ,
    OP_POLL,
    OP_REPLY_STATUS,
    OP_REPLY_FRAME,
    OP_REPLY_SEARCH
  } op_kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CONV,
    B_PUSH,
    B_READ,
    B_DONE
  } back_state_t;

  typedef struct packed {
    op_kind_t             kind;
    act_t                 act;
    logic [DIGITS_W-1:0]  digits;
    logic [FRAME_W-1:0]   frame;
    logic                 paused;
  } op_t;

endpackage

// ----- hdl/ldsc_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ldsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ldsc_front.sv -----
// front end: accepts items, collects command bytes, classifies commands
`timescale 1ns / 1ps

module ldsc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ldsc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic [ldsc_pkg::IN_USER_W-1:0] s_axis_tuser,
  input  logic                           q_full,
  output logic                           op_valid,
  output ldsc_pkg::op_t                  op
);

  logic [7:0]                     cmd [ldsc_pkg::CMD_KEEP];
  logic [ldsc_pkg::CMD_LEN_W-1:0] cmd_len;
  logic [ldsc_pkg::CMD_LEN_W-1:0] cmd_len_next;
  logic                           cmd_we;

  ldsc_pkg::req_t               req;
  logic [7:0]                   data_byte;
  logic [ldsc_pkg::FRAME_W-1:0] frame_in;
  logic                         player_paused;
  logic [7:0]                   c0;
  logic [7:0]                   c1;
  logic [7:0]                   c6;
  logic                         is_digit;

  assign req           = ldsc_pkg::req_t'(s_axis_tuser);
  assign data_byte     = s_axis_tdata[7:0];
  assign frame_in      = s_axis_tdata[23:8];
  assign player_paused = s_axis_tdata[24];

  assign s_axis_tready = !q_full;
  assign op_valid      = s_axis_tvalid && s_axis_tready;

  assign c0 = (cmd_len > 5'd0) ? cmd[0] : 8'd0;
  assign c1 = (cmd_len > 5'd1) ? cmd[1] : 8'd0;
  assign c6 = (cmd_len > 5'd6) ? cmd[6] : 8'd0;
  assign is_digit = (data_byte >= ldsc_pkg::CHR_ZERO) && (data_byte <= ldsc_pkg::CHR_NINE);

  always_comb begin
    op.kind   = ldsc_pkg::OP_REPORT;
    op.act    = ldsc_pkg::ACT_NONE;
    op.digits = '0;
    op.frame  = frame_in;
    op.paused = player_paused;
    cmd_len_next = cmd_len;
    cmd_we = 1'b0;
    unique case (req)
      ldsc_pkg::REQ_WRITE: begin
        if (data_byte == ldsc_pkg::CHR_CR) begin
          cmd_len_next = '0;
          unique case (c0) inside
            ldsc_pkg::CHR_STAR, ldsc_pkg::CHR_SLASH: begin
              op.act = ldsc_pkg::ACT_PAUSE;
            end
            ldsc_pkg::CHR_COMMA: begin
              if (c1 == ldsc_pkg::CHR_ONE) begin
                op.kind = ldsc_pkg::OP_REPLY_STATUS;
              end
            end
            ldsc_pkg::CHR_QUEST: begin
              if (c1 == ldsc_pkg::CHR_F) begin
                op.kind = ldsc_pkg::OP_REPLY_FRAME;
              end
            end
            ldsc_pkg::CHR_A: begin
              if (c1 == ldsc_pkg::CHR_ZERO) begin
                op.act = ldsc_pkg::ACT_AUDIO1_OFF;
              end else if (c1 == ldsc_pkg::CHR_ONE) begin
                op.act = ldsc_pkg::ACT_AUDIO1_ON;
              end
            end
            ldsc_pkg::CHR_B: begin
              if (c1 == ldsc_pkg::CHR_ZERO) begin
                op.act = ldsc_pkg::ACT_AUDIO2_OFF;
              end else if (c1 == ldsc_pkg::CHR_ONE) begin
                op.act = ldsc_pkg::ACT_AUDIO2_ON;
              end
            end
            ldsc_pkg::CHR_F: begin
              if (cmd_len == 5'd7 && (c6 == ldsc_pkg::CHR_R || c6 == ldsc_pkg::CHR_N)) begin
                op.kind   = ldsc_pkg::OP_REPLY_SEARCH;
                op.act    = (c6 == ldsc_pkg::CHR_N) ? ldsc_pkg::ACT_SEARCH_PLAY
                                                    : ldsc_pkg::ACT_SEARCH_HOLD;
                op.digits = {cmd[1], cmd[2], cmd[3], cmd[4], cmd[5]};
              end
            end
            ldsc_pkg::CHR_N: begin
              op.act = ldsc_pkg::ACT_PLAY_RESTORE;
            end
            ldsc_pkg::CHR_U: begin
              op.act = ldsc_pkg::ACT_PLAY_MUTED;
            end
            default: begin
            end
          endcase
        end else if (!(is_digit && cmd_len == '0)) begin
          if (cmd_len < ldsc_pkg::CMD_LEN_W'(ldsc_pkg::CMD_MAX)) begin
            cmd_len_next = cmd_len + 5'd1;
            cmd_we = cmd_len < ldsc_pkg::CMD_LEN_W'(ldsc_pkg::CMD_KEEP);
          end
        end
      end
      ldsc_pkg::REQ_READ: begin
        op.kind = ldsc_pkg::OP_READ;
      end
      ldsc_pkg::REQ_POLL: begin
        op.kind = ldsc_pkg::OP_POLL;
      end
      ldsc_pkg::REQ_NOP: begin
      end
      default: begin
      end
    endcase
  end

  // only the first bytes of a command are ever decoded
  always_ff @(posedge clk) begin
    if (op_valid && cmd_we) begin
      cmd[cmd_len[ldsc_pkg::CMD_IDX_W-1:0]] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_len <= '0;
    end else if (op_valid) begin
      cmd_len <= cmd_len_next;
    end
  end

endmodule

// ----- hdl/ldsc_queue.sv -----
// short operation queue between front and back end
`timescale 1ns / 1ps

module ldsc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  ldsc_pkg::op_t wr_op,
  output logic          full,
  input  logic          rd_en,
  output logic          rd_valid,
  output ldsc_pkg::op_t rd_op
);

  ldsc_pkg::op_t                 slots [ldsc_pkg::QUEUE_DEPTH];
  logic [ldsc_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ldsc_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ldsc_pkg::QUEUE_CW-1:0] count;

  assign full     = count == ldsc_pkg::QUEUE_CW'(ldsc_pkg::QUEUE_DEPTH);
  assign rd_valid = count != '0;
  assign rd_op    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/ldsc_back.sv -----
// back end: reply queue, search and audio state, result register
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ldsc_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  ldsc_pkg::op_t                   q_op,
  output logic                            q_pop,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [ldsc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  ldsc_pkg::back_state_t state;
  ldsc_pkg::back_state_t state_next;

  logic [ldsc_pkg::REPLY_AW-1:0] reply_head;
  logic [ldsc_pkg::REPLY_CW-1:0] reply_count;
  logic                          search_waiting;
  logic                          play_waiting;
  logic                          left_audio_flag;
  logic                          right_audio_flag;

  ldsc_pkg::op_kind_t              cur_kind;
  ldsc_pkg::act_t                  act_r;
  logic [ldsc_pkg::DIGITS_W-1:0]   digits_r;
  logic [7:0]                      rd_byte;
  logic                            dropped;
  logic [ldsc_pkg::FRAME_W-1:0]    frame_val;
  logic [19:0]                     dig;
  logic [2:0]                      conv_cnt;
  logic [ldsc_pkg::PUSH_IDX_W-1:0] push_idx;

  logic                            ram_we;
  logic [ldsc_pkg::REPLY_AW-1:0]   ram_waddr;
  logic [7:0]                      ram_wdata;
  logic [7:0]                      ram_rdata;
  logic                            out_load;
  logic                            out_free;
  logic [ldsc_pkg::PUSH_IDX_W-1:0] push_last;
  logic                            poll_release;

  logic [31:0]                     prod;
  logic [ldsc_pkg::QUOT_W-1:0]     quot;
  logic [ldsc_pkg::FRAME_W-1:0]    quot_ten;
  logic [3:0]                      rem;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign ram_waddr = reply_head + reply_count[ldsc_pkg::REPLY_AW-1:0];
  assign poll_release = search_waiting && q_op.paused;

  // one decimal digit per cycle, least significant first
  assign prod     = frame_val * ldsc_pkg::RECIP_TEN;
  assign quot     = prod[31:ldsc_pkg::RECIP_SHIFT];
  assign quot_ten = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = 4'(frame_val - quot_ten);

  ldsc_ram #(
    .WIDTH (8),
    .DEPTH (ldsc_pkg::REPLY_DEPTH)
  ) u_reply_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (reply_head),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_wdata = ldsc_pkg::CHR_CR;
    push_last = '0;
    case (cur_kind)
      ldsc_pkg::OP_REPLY_STATUS: begin
        push_last = ldsc_pkg::PUSH_LAST_STATUS;
        if (push_idx == '0) begin
          ram_wdata = ldsc_pkg::CHR_S;
        end
      end
      ldsc_pkg::OP_REPLY_SEARCH: begin
        push_last = ldsc_pkg::PUSH_LAST_SEARCH;
        if (push_idx == 3'd0) begin
          ram_wdata = ldsc_pkg::CHR_A;
        end else if (push_idx == 3'd1) begin
          ram_wdata = (act_r == ldsc_pkg::ACT_SEARCH_PLAY) ? ldsc_pkg::CHR_ONE
                                                            : ldsc_pkg::CHR_ZERO;
        end
      end
      ldsc_pkg::OP_REPLY_FRAME: begin
        push_last = ldsc_pkg::PUSH_LAST_FRAME;
        if (push_idx == 3'd0) begin
          ram_wdata = ldsc_pkg::CHR_F;
        end else if (push_idx != ldsc_pkg::PUSH_LAST_FRAME) begin
          ram_wdata = ldsc_pkg::CHR_ZERO + {4'd0, dig[19:16]};
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ldsc_pkg::B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_op.kind) inside
            ldsc_pkg::OP_READ: begin
              state_next = (reply_count != '0) ? ldsc_pkg::B_READ : ldsc_pkg::B_DONE;
            end
            ldsc_pkg::OP_REPLY_STATUS, ldsc_pkg::OP_REPLY_SEARCH: begin
              state_next = ldsc_pkg::B_PUSH;
            end
            ldsc_pkg::OP_REPLY_FRAME: begin
              state_next = ldsc_pkg::B_CONV;
            end
            default: begin
              state_next = ldsc_pkg::B_DONE;
            end
          endcase
        end
      end
      ldsc_pkg::B_CONV: begin
        if (conv_cnt == ldsc_pkg::CONV_LAST) begin
          state_next = ldsc_pkg::B_PUSH;
        end
      end
      ldsc_pkg::B_PUSH: begin
        ram_we = reply_count != ldsc_pkg::REPLY_FULL;
        if (push_idx == push_last) begin
          state_next = ldsc_pkg::B_DONE;
        end
      end
      ldsc_pkg::B_READ: begin
        state_next = ldsc_pkg::B_DONE;
      end
      ldsc_pkg::B_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ldsc_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = ldsc_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ldsc_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_head       <= '0;
      reply_count      <= '0;
      search_waiting   <= 1'b0;
      play_waiting     <= 1'b0;
      left_audio_flag  <= 1'b1;
      right_audio_flag <= 1'b1;
      m_axis_tvalid    <= 1'b0;
    end else begin
      if (q_pop) begin
        case (q_op.act)
          ldsc_pkg::ACT_AUDIO1_OFF: left_audio_flag  <= 1'b0;
          ldsc_pkg::ACT_AUDIO1_ON:  left_audio_flag  <= 1'b1;
          ldsc_pkg::ACT_AUDIO2_OFF: right_audio_flag <= 1'b0;
          ldsc_pkg::ACT_AUDIO2_ON:  right_audio_flag <= 1'b1;
          default: begin
          end
        endcase
        if (q_op.kind == ldsc_pkg::OP_REPLY_SEARCH) begin
          search_waiting <= 1'b1;
          if (q_op.act == ldsc_pkg::ACT_SEARCH_PLAY) begin
            play_waiting <= 1'b1;
          end
        end
        if (q_op.kind == ldsc_pkg::OP_POLL && poll_release) begin
          search_waiting <= 1'b0;
          play_waiting   <= 1'b0;
        end
      end
      if (state == ldsc_pkg::B_READ) begin
        reply_head  <= reply_head + 1'b1;
        reply_count <= reply_count - 1'b1;
      end else if (ram_we) begin
        reply_count <= reply_count + 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_kind  <= q_op.kind;
      act_r     <= (q_op.kind == ldsc_pkg::OP_POLL && poll_release && play_waiting)
                   ? ldsc_pkg::ACT_PLAY_RESTORE : q_op.act;
      digits_r  <= q_op.digits;
      rd_byte   <= '0;
      dropped   <= 1'b0;
      frame_val <= q_op.frame;
      conv_cnt  <= '0;
      push_idx  <= '0;
    end
    if (state == ldsc_pkg::B_CONV) begin
      frame_val <= {3'd0, quot};
      dig       <= {rem, dig[19:4]};
      conv_cnt  <= conv_cnt + 1'b1;
    end
    if (state == ldsc_pkg::B_PUSH) begin
      push_idx <= push_idx + 1'b1;
      if (cur_kind == ldsc_pkg::OP_REPLY_FRAME && push_idx != '0) begin
        dig <= {dig[15:0], 4'd0};
      end
      if (!ram_we) begin
        dropped <= 1'b1;
      end
    end
    if (state == ldsc_pkg::B_READ) begin
      rd_byte <= ram_rdata;
    end
    if (out_load) begin
      m_axis_tdata <= {dropped, right_audio_flag, left_audio_flag, digits_r, act_r,
                       !search_waiting && reply_count != '0, rd_byte};
    end
  end

  `ASSERT_IMPLIES(a_play_needs_search, clk, rst, play_waiting, search_waiting, "play pending without search")
  `ASSERT_NEXT(a_full_queue_drops, clk, rst, state == ldsc_pkg::B_PUSH && reply_count == ldsc_pkg::REPLY_FULL, dropped, "full reply queue did not flag a drop")
  `ASSERT_IMPLIES(a_read_not_empty, clk, rst, state == ldsc_pkg::B_READ, reply_count != '0, "reply read from empty queue")
  `ASSERT_IMPLIES(a_result_from_done, clk, rst, $rose(m_axis_tvalid), $past(state) == ldsc_pkg::B_DONE, "result raised outside done state")

endmodule

// ----- hdl/laserdisc_serial_command_decoder_core.sv -----
// top level of the player-side serial command decoder
`timescale 1ns / 1ps

// Input channel s_axis: one item per request; tuser carries the request kind
// (write command byte, read reply byte, poll, no-op), tdata the byte, the current
// frame and the paused flag. Output channel m_axis: exactly one result per item,
// in order: popped reply byte, data-ready, player action, search digits, audio
// enables and the reply overflow flag.
// The front end accepts an item per cycle while its 4-entry operation queue has
// room; command bytes are collected and decoded there in the accept cycle.
// The back end runs one operation at a time: a plain item goes from idle to done,
// a read passes a read state (registered reply ram read) if replies are queued,
// the status and search replies push their bytes, the frame reply first converts
// the frame to decimal digits, then pushes one reply byte per cycle, before done.
// A result waits in the output register while m_axis_tready is low; the back
// end then holds, the queue fills and s_axis_tready drops.
// Reset empties both queues, clears search and play pending and sets both
// audio enables; no clearing pass is needed.
module laserdisc_serial_command_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_byte, frame_in, player_paused
  input  logic [1:0]  s_axis_tuser,  // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // read_byte, data_ready, player_action, search_digits, audio_left_on,
  // audio_right_on, reply_overflow
  output logic [55:0] m_axis_tdata
);

  logic          op_valid;
  ldsc_pkg::op_t op;
  logic          q_full;
  logic          q_pop;
  logic          q_valid;
  ldsc_pkg::op_t q_op;

  ldsc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .op_valid      (op_valid),
    .op            (op)
  );

  ldsc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (op_valid),
    .wr_op    (op),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_op    (q_op)
  );

  ldsc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_op          (q_op),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
